// ===== hdl/pli_pkg.sv =====
// Package: shared constants, types and codes of the positional list insert block.
package pli_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] STAT_ELEMENT = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERR,
        ST_FWD,
        ST_BWD
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTL,
        OP_ROTR
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic [POS_W-1:0]          pos;
        logic [CNT_W-1:0]          count;
        logic signed [DATA_W-1:0]  value;
    } t_cell_cmd;

endpackage

// ===== hdl/pli_if.sv =====
// Interfaces: input and result channels with valid/ready handshake.
interface pli_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [pli_pkg::POS_W-1:0]            position;
    logic signed [pli_pkg::DATA_W-1:0]    value;

    modport source (output valid, output position, output value, input ready);
    modport sink   (input valid, input position, input value, output ready);
endinterface

interface pli_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic                                 direction;
    logic signed [pli_pkg::DATA_W-1:0]    element;
    logic                                 last;

    modport source (output valid, output status, output direction, output element,
                    output last, input ready);
    modport sink   (input valid, input status, input direction, input element,
                    input last, output ready);
endinterface

// ===== hdl/pli_cell.sv =====
// One list cell: holds an entry and moves it to or from its neighbors on command.
module pli_cell (
    input  logic                                i_clk,
    input  logic [pli_pkg::IDX_W-1:0]           i_idx,
    input  pli_pkg::t_cell_cmd                  i_cmd,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_prev,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_next,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_head,
    output logic signed [pli_pkg::DATA_W-1:0]   o_entry
);

    logic signed [pli_pkg::DATA_W-1:0] r_entry;
    logic signed [pli_pkg::DATA_W-1:0] n_entry;
    logic [pli_pkg::CNT_W-1:0]         w_idx_c;
    logic [pli_pkg::POS_W-1:0]         w_idx_p;

    assign w_idx_c = pli_pkg::CNT_W'(i_idx);
    assign w_idx_p = pli_pkg::POS_W'(i_idx);

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            pli_pkg::OP_HOLD: begin
                n_entry = r_entry;
            end
            pli_pkg::OP_INSERT: begin
                if (w_idx_p == i_cmd.pos) begin
                    n_entry = i_cmd.value;
                end else if (w_idx_p > i_cmd.pos && w_idx_c <= i_cmd.count) begin
                    n_entry = i_prev;
                end
            end
            // rotate toward the front; the head wraps to the tail slot
            pli_pkg::OP_ROTL: begin
                if (w_idx_c + 1'b1 == i_cmd.count) begin
                    n_entry = i_head;
                end else if (w_idx_c < i_cmd.count) begin
                    n_entry = i_next;
                end
            end
            // rotate toward the back; cell 0 sees the tail on i_prev
            pli_pkg::OP_ROTR: begin
                if (w_idx_c < i_cmd.count) begin
                    n_entry = i_prev;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/positional_list_insert.sv =====
// Top level: positional list insert with a chain of entry cells and an output register.
// An insert is taken in idle; results follow one per cycle unless the output stalls.
// A successful insert gives count beats forward, then count backward (count after the
// insert), from rotations of the cell chain; an error gives a single beat.
// Input ready is high in idle, also while the final result beat still waits in the register.
// Synchronous active-low reset clears count, sequencer and output valid; entries are unset.
module positional_list_insert (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pli_in_if.sink     i_in,
    pli_out_if.source  o_out
);

    localparam int CAP = pli_pkg::CAPACITY;

    pli_pkg::t_state                   r_state, n_state;
    logic [pli_pkg::CNT_W-1:0]         r_count, n_count;
    logic [pli_pkg::CNT_W-1:0]         r_pass, n_pass;
    logic [1:0]                        r_err, n_err;

    logic                              r_ov;
    logic [1:0]                        r_status;
    logic                              r_dir;
    logic signed [pli_pkg::DATA_W-1:0] r_elem;
    logic                              r_last;

    logic                              w_acc, w_adv, w_load, w_pos_bad, w_full, w_pass_end;
    logic [1:0]                        w_status;
    logic                              w_dir, w_last;
    logic signed [pli_pkg::DATA_W-1:0] w_elem;
    pli_pkg::t_cell_cmd                w_cmd;
    logic [pli_pkg::CNT_W-1:0]         w_cnt_m1;
    logic signed [pli_pkg::DATA_W-1:0] w_entry [CAP];
    logic signed [pli_pkg::DATA_W-1:0] w_head, w_tail;

    assign i_in.ready = (r_state == pli_pkg::ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_adv      = !r_ov || o_out.ready;
    assign w_pos_bad  = i_in.position > pli_pkg::POS_W'(r_count);
    assign w_full     = (r_count == pli_pkg::CNT_W'(CAP));
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_pass_end = (r_pass == w_cnt_m1);
    assign w_head     = w_entry[0];
    assign w_tail     = w_entry[w_cnt_m1[pli_pkg::IDX_W-1:0]];

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pass  = r_pass;
        n_err   = r_err;
        unique case (r_state)
            pli_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (w_pos_bad) begin
                        n_err   = pli_pkg::STAT_INVALID;
                        n_state = pli_pkg::ST_ERR;
                    end else if (w_full) begin
                        n_err   = pli_pkg::STAT_FULL;
                        n_state = pli_pkg::ST_ERR;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_pass  = '0;
                        n_state = pli_pkg::ST_FWD;
                    end
                end
            end
            pli_pkg::ST_ERR: begin
                if (w_adv) n_state = pli_pkg::ST_IDLE;
            end
            pli_pkg::ST_FWD: begin
                if (w_adv) begin
                    if (w_pass_end) begin
                        n_pass  = '0;
                        n_state = pli_pkg::ST_BWD;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                end
            end
            pli_pkg::ST_BWD: begin
                if (w_adv) begin
                    if (w_pass_end) begin
                        n_state = pli_pkg::ST_IDLE;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                end
            end
            default: n_state = pli_pkg::ST_IDLE;
        endcase
    end

    // outputs: cell command and result beat
    always_comb begin
        w_cmd.op    = pli_pkg::OP_HOLD;
        w_cmd.pos   = i_in.position;
        w_cmd.count = r_count;
        w_cmd.value = i_in.value;
        w_load      = 1'b0;
        w_status    = pli_pkg::STAT_ELEMENT;
        w_dir       = pli_pkg::DIR_FWD;
        w_elem      = '0;
        w_last      = 1'b0;
        unique case (r_state)
            pli_pkg::ST_IDLE: begin
                if (w_acc && !w_pos_bad && !w_full) w_cmd.op = pli_pkg::OP_INSERT;
            end
            pli_pkg::ST_ERR: begin
                w_load   = w_adv;
                w_status = r_err;
                w_last   = 1'b1;
            end
            pli_pkg::ST_FWD: begin
                w_load = w_adv;
                w_elem = w_head;
                if (w_adv) w_cmd.op = pli_pkg::OP_ROTL;
            end
            pli_pkg::ST_BWD: begin
                w_load = w_adv;
                w_dir  = pli_pkg::DIR_BWD;
                w_elem = w_tail;
                w_last = w_pass_end;
                if (w_adv) w_cmd.op = pli_pkg::OP_ROTR;
            end
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::ST_IDLE;
            r_count <= '0;
            r_pass  <= '0;
            r_err   <= pli_pkg::STAT_ELEMENT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pass  <= n_pass;
            r_err   <= n_err;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_status;
            r_dir    <= w_dir;
            r_elem   <= w_elem;
            r_last   <= w_last;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.status    = r_status;
    assign o_out.direction = r_dir;
    assign o_out.element   = r_elem;
    assign o_out.last      = r_last;

    // cell chain; cell 0 wraps to the tail, the end cell to the head
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        pli_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (pli_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_prev  ((g == 0) ? w_tail : w_entry[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == CAP - 1) ? w_head : w_entry[(g == CAP - 1) ? g : g + 1]),
            .i_head  (w_head),
            .o_entry (w_entry[g])
        );
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pli_pkg::CNT_W'(CAP))
        else $error("list count above capacity");

    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pli_pkg::ST_FWD || r_state == pli_pkg::ST_BWD) |-> r_pass < r_count)
        else $error("pass counter past list count");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_pos_bad && !w_full) |=> r_count == $past(r_count) + 1'b1)
        else $error("successful insert did not grow count");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_status != pli_pkg::STAT_ELEMENT) |-> r_last)
        else $error("error beat not marked last");

    a_last_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last && r_status == pli_pkg::STAT_ELEMENT) |-> r_dir == pli_pkg::DIR_BWD)
        else $error("final element beat not in backward pass");

endmodule

// ===== bench/pli_checker.sv =====
// Checker: watches both channels, predicts each insert's list walk and compares result beats.
module pli_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pli_in_if    i_in_mon,
    pli_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                        status;
        logic                              direction;
        logic signed [pli_pkg::DATA_W-1:0] element;
        logic                              last;
    } t_walk_beat;

    logic signed [pli_pkg::DATA_W-1:0] list_mem [pli_pkg::CAPACITY];
    int                                list_len;
    t_walk_beat                        walk_beats [$];
    t_walk_beat                        want_beat;
    int                                fails = 0;

    task automatic push_beat(input logic [1:0] st, input logic dir,
                             input logic signed [pli_pkg::DATA_W-1:0] el, input logic lst);
        t_walk_beat b;
        b.status    = st;
        b.direction = dir;
        b.element   = el;
        b.last      = lst;
        walk_beats.push_back(b);
    endtask

    // Position check comes before the full check.
    task automatic insert_and_walk(input logic [pli_pkg::POS_W-1:0] pos,
                                   input logic signed [pli_pkg::DATA_W-1:0] val);
        int k;
        if (int'(pos) > list_len) begin
            push_beat(pli_pkg::STAT_INVALID, pli_pkg::DIR_FWD, '0, 1'b1);
        end else if (list_len >= pli_pkg::CAPACITY) begin
            push_beat(pli_pkg::STAT_FULL, pli_pkg::DIR_FWD, '0, 1'b1);
        end else begin
            for (k = list_len; k > int'(pos); k--)
                list_mem[k] = list_mem[k-1];
            list_mem[int'(pos)] = val;
            list_len++;
            for (k = 0; k < list_len; k++)
                push_beat(pli_pkg::STAT_ELEMENT, pli_pkg::DIR_FWD, list_mem[k], 1'b0);
            for (k = list_len - 1; k >= 0; k--)
                push_beat(pli_pkg::STAT_ELEMENT, pli_pkg::DIR_BWD, list_mem[k], k == 0);
        end
    endtask

    task automatic match_field(input string fname, input logic [pli_pkg::DATA_W-1:0] exp_val,
                               input logic [pli_pkg::DATA_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            walk_beats.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (walk_beats.size() == 0) begin
                    $error("result beat with nothing expected: status %0d element 0x%0h",
                           i_out_mon.status, i_out_mon.element);
                    fails++;
                end else begin
                    want_beat = walk_beats.pop_front();
                    match_field("status", pli_pkg::DATA_W'(want_beat.status),
                                pli_pkg::DATA_W'(i_out_mon.status));
                    match_field("direction", pli_pkg::DATA_W'(want_beat.direction),
                                pli_pkg::DATA_W'(i_out_mon.direction));
                    match_field("element", want_beat.element, i_out_mon.element);
                    match_field("last", pli_pkg::DATA_W'(want_beat.last),
                                pli_pkg::DATA_W'(i_out_mon.last));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                insert_and_walk(i_in_mon.position, i_in_mon.value);
        end
        o_fail_count <= fails;
        o_pending    <= walk_beats.size();
    end

endmodule

// ===== bench/positional_list_insert_tb.sv =====
// Testbench top: clock, reset, insert stimulus, result back-pressure, watchdog and verdict.
module positional_list_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 230;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   list_fill   = 0;

    pli_in_if  in_ch ();
    pli_out_if out_ch ();

    positional_list_insert dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pli_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly back-to-back or short, a few long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [pli_pkg::DATA_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        case (r % 8)
            0: if (r < 12) return 32'sh7fff_ffff;
            1: if (r < 12) return 32'sh8000_0000;
            2: if (r < 12) return '0;
            3: if (r < 12) return '1;
            default: ;
        endcase
        return $urandom;
    endfunction

    // While the list has room, mostly legal positions; once full, full and invalid mixed.
    function automatic logic [pli_pkg::POS_W-1:0] random_position();
        int r;
        r = $urandom_range(0, 99);
        if (list_fill < pli_pkg::CAPACITY) begin
            if (r < 30)
                return pli_pkg::POS_W'(list_fill);
            else if (r < 45)
                return '0;
            else if (r < 85)
                return pli_pkg::POS_W'($urandom_range(0, list_fill));
            return pli_pkg::POS_W'($urandom_range(list_fill + 1, 255));
        end
        if (r < 50)
            return pli_pkg::POS_W'($urandom_range(0, pli_pkg::CAPACITY));
        else if (r < 65)
            return pli_pkg::POS_W'(pli_pkg::CAPACITY + 1);
        else if (r < 75)
            return '1;
        return pli_pkg::POS_W'($urandom_range(pli_pkg::CAPACITY + 1, 255));
    endfunction

    task automatic send_insert(input logic [pli_pkg::POS_W-1:0] pos,
                               input logic signed [pli_pkg::DATA_W-1:0] val, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : random_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.position <= pos;
        in_ch.value    <= val;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
        if (int'(pos) <= list_fill && list_fill < pli_pkg::CAPACITY)
            list_fill++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : ready_drv
        int r;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            out_ch.ready <= 1'b1;
            if (r < 15) begin
                repeat ($urandom_range(40, 80)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ch.ready <= 1'b0;
                repeat (random_gap() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stim
        int  i;
        bit  burst;
        in_ch.valid    <= 1'b0;
        in_ch.position <= '0;
        in_ch.value    <= '0;
        rst_n          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty list first: any nonzero position is invalid; then legal and invalid inserts mixed
        send_insert(pli_pkg::POS_W'(1), 32'sd5, 1'b0);
        send_insert('1, '1, 1'b0);
        send_insert('0, 32'sh7fff_ffff, 1'b0);
        send_insert(pli_pkg::POS_W'(1), 32'sh8000_0000, 1'b1);
        send_insert(pli_pkg::POS_W'(1), '0, 1'b1);
        send_insert('0, 32'sh5a5a_a5a5, 1'b0);
        send_insert(pli_pkg::POS_W'(5), 32'sh1234_5678, 1'b0);
        send_insert(pli_pkg::POS_W'(4), -32'sd77, 1'b1);
        send_insert(pli_pkg::POS_W'(128), 32'sh0f0f_0f0f, 1'b0);
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            burst = (i % 50) >= 30 && (i % 50) < 45;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            send_insert(random_position(), random_value(), burst);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
